/* rtl/kms_pkg.sv */
// Shared types and constants for the keyframe motion sequencer.
package kms_pkg;

  localparam int MOTION_COUNT    = 8;
  localparam int KEYS_PER_MOTION = 16;
  localparam int FRAME_BITS      = 16;

  localparam int MOTION_W   = $clog2(MOTION_COUNT);
  localparam int KEY_W      = $clog2(KEYS_PER_MOTION);
  localparam int CNT_W      = $clog2(KEYS_PER_MOTION + 1);
  localparam int DUR_W      = 16;
  localparam int VALUE_W    = 16;
  localparam int BLEND_W    = 8;
  localparam int DUR_DEPTH  = MOTION_COUNT * KEYS_PER_MOTION;
  localparam int DUR_ADDR_W = $clog2(DUR_DEPTH);

  localparam logic [FRAME_BITS-1:0] FRAME_MAX   = '1;
  localparam logic [BLEND_W-1:0]    BLEND_RESET = BLEND_W'(5);
  localparam logic [CNT_W-1:0]      KEYS_MAX    = CNT_W'(KEYS_PER_MOTION);

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_SELECT    = 2'd1,
    CMD_LOAD_DUR  = 2'd2,
    CMD_LOAD_INFO = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                  command;
    logic [MOTION_W-1:0]   motion_id;
    logic [KEY_W-1:0]      key_index;
    logic [VALUE_W-1:0]    load_value;
    logic                  loop_enable;
  } in_word_t;

  typedef struct packed {
    logic [MOTION_W-1:0]   current_motion;
    logic [KEY_W-1:0]      current_key;
    logic [FRAME_BITS-1:0] current_frame;
    logic [MOTION_W-1:0]   previous_motion;
    logic [KEY_W-1:0]      previous_key;
    logic [FRAME_BITS-1:0] previous_frame;
    logic                  blending;
    logic                  finished;
    logic                  playing;
  } out_word_t;

  typedef struct packed {
    logic                  dur_we;
    logic [DUR_ADDR_W-1:0] dur_addr;
    logic [DUR_W-1:0]      dur_data;
    logic                  info_we;
    logic [MOTION_W-1:0]   info_addr;
    logic [CNT_W-1:0]      info_count;
    logic                  info_loop;
  } tbl_wr_t;

  typedef struct packed {
    logic [MOTION_W-1:0]   cur_motion;
    logic [KEY_W-1:0]      cur_key;
    logic [MOTION_W-1:0]   old_motion;
    logic [KEY_W-1:0]      old_key;
  } tbl_rd_t;

  typedef struct packed {
    logic [DUR_W-1:0]      cur_dur;
    logic [DUR_W-1:0]      old_dur;
    logic [CNT_W-1:0]      cur_cnt;
    logic [CNT_W-1:0]      old_cnt;
    logic                  cur_loop;
    logic                  old_loop;
  } tbl_data_t;

  typedef struct packed {
    logic [CNT_W-1:0]      count;
    logic                  loop;
  } info_t;

endpackage

/* rtl/kms_in_if.sv */
// Input command channel: valid, ready and one command word.
interface kms_in_if;
  import kms_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/kms_out_if.sv */
// Result channel: valid, ready and one status word.
interface kms_out_if;
  import kms_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/kms_cfg_if.sv */
// Configuration write channel: valid, ready and the blend length.
interface kms_cfg_if;
  import kms_pkg::*;

  logic               valid;
  logic               ready;
  logic [BLEND_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/kms_tables.sv */
// Key duration and motion info memories with registered, forwarded read ports.
module kms_tables (
  input  logic                clk,
  input  kms_pkg::tbl_wr_t    wr,
  input  kms_pkg::tbl_rd_t    rd,
  output kms_pkg::tbl_data_t  rdata
);
  import kms_pkg::*;

  logic [DUR_W-1:0]      dur_mem [DUR_DEPTH];
  info_t                 info_mem [MOTION_COUNT];
  tbl_data_t             rdata_r;
  logic [DUR_ADDR_W-1:0] cur_addr;
  logic [DUR_ADDR_W-1:0] old_addr;
  info_t                 wr_info;
  logic                  cur_info_hit;
  logic                  old_info_hit;

  assign cur_addr     = {rd.cur_motion, rd.cur_key};
  assign old_addr     = {rd.old_motion, rd.old_key};
  assign wr_info      = '{count: wr.info_count, loop: wr.info_loop};
  assign cur_info_hit = wr.info_we && wr.info_addr == rd.cur_motion;
  assign old_info_hit = wr.info_we && wr.info_addr == rd.old_motion;

  always_ff @(posedge clk) begin
    if (wr.dur_we) begin
      dur_mem[wr.dur_addr] <= wr.dur_data;
    end
    if (wr.info_we) begin
      info_mem[wr.info_addr] <= wr_info;
    end
  end

  // A write in the same cycle is passed straight to the read register.
  always_ff @(posedge clk) begin
    rdata_r.cur_dur  <= (wr.dur_we && wr.dur_addr == cur_addr) ? wr.dur_data
                                                                : dur_mem[cur_addr];
    rdata_r.old_dur  <= (wr.dur_we && wr.dur_addr == old_addr) ? wr.dur_data
                                                                : dur_mem[old_addr];
    rdata_r.cur_cnt  <= cur_info_hit ? wr.info_count : info_mem[rd.cur_motion].count;
    rdata_r.cur_loop <= cur_info_hit ? wr.info_loop  : info_mem[rd.cur_motion].loop;
    rdata_r.old_cnt  <= old_info_hit ? wr.info_count : info_mem[rd.old_motion].count;
    rdata_r.old_loop <= old_info_hit ? wr.info_loop  : info_mem[rd.old_motion].loop;
  end

  assign rdata = rdata_r;

endmodule

/* rtl/kms_core.sv */
// Sequencer state registers and the per-word tick, select and load update.
module kms_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  kms_pkg::in_word_t      item,
  input  logic [kms_pkg::BLEND_W-1:0] blend_frames,
  input  kms_pkg::tbl_data_t     tbl,
  output kms_pkg::tbl_wr_t       tbl_wr,
  output kms_pkg::tbl_rd_t       tbl_rd,
  output kms_pkg::out_word_t     status_nxt
);
  import kms_pkg::*;

  logic [MOTION_W-1:0]   active_r, active_nxt;
  logic [MOTION_W-1:0]   prior_r, prior_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [KEY_W-1:0]      pkey_r, pkey_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [FRAME_BITS-1:0] pframe_r, pframe_nxt;
  logic                  selected_r, selected_nxt;
  logic                  blend_r, blend_nxt;
  logic                  done_r, done_nxt;

  logic [FRAME_BITS-1:0] fc;
  logic [FRAME_BITS-1:0] pfc;
  logic [CNT_W-1:0]      kp;
  logic [CNT_W-1:0]      pk;
  logic [CNT_W-1:0]      cur_cnt;
  logic [CNT_W-1:0]      old_cnt;
  logic [CNT_W-1:0]      load_cnt;

  assign cur_cnt = (tbl.cur_cnt == '0) ? CNT_W'(1) : tbl.cur_cnt;
  assign old_cnt = (tbl.old_cnt == '0) ? CNT_W'(1) : tbl.old_cnt;

  always_comb begin
    if (item.load_value == '0) begin
      load_cnt = CNT_W'(1);
    end else if (item.load_value > VALUE_W'(KEYS_PER_MOTION)) begin
      load_cnt = KEYS_MAX;
    end else begin
      load_cnt = item.load_value[CNT_W-1:0];
    end
  end

  always_comb begin
    active_nxt   = active_r;
    prior_nxt    = prior_r;
    key_nxt      = key_r;
    pkey_nxt     = pkey_r;
    frame_nxt    = frame_r;
    pframe_nxt   = pframe_r;
    selected_nxt = selected_r;
    blend_nxt    = blend_r;
    done_nxt     = done_r;
    tbl_wr       = '0;
    fc           = (frame_r == FRAME_MAX) ? frame_r : frame_r + 1'b1;
    pfc          = pframe_r;
    kp           = {1'b0, key_r};
    pk           = {1'b0, pkey_r};

    if (adv) begin
      case (item.command)
        CMD_TICK: begin
          if (selected_r && !done_r) begin
            if (blend_r && tbl.old_loop && pframe_r != FRAME_MAX) begin
              pfc = pframe_r + 1'b1;
            end
            if (blend_r && FRAME_BITS'(blend_frames) < fc) begin
              blend_nxt = 1'b0;
            end else if (!blend_r) begin
              if (tbl.cur_dur <= fc) begin
                kp = kp + 1'b1;
                fc = '0;
              end
            end else begin
              if (tbl.cur_dur < fc) begin
                kp = kp + 1'b1;
                fc = '0;
              end
              if (tbl.old_dur < pfc) begin
                pk  = pk + 1'b1;
                pfc = '0;
              end
            end
            if (kp >= cur_cnt) begin
              if (!tbl.cur_loop) begin
                kp       = cur_cnt - 1'b1;
                done_nxt = 1'b1;
              end else begin
                kp = '0;
                fc = '0;
              end
            end
            if (pk >= old_cnt) begin
              pk = old_cnt - 1'b1;
            end
            key_nxt    = kp[KEY_W-1:0];
            pkey_nxt   = pk[KEY_W-1:0];
            frame_nxt  = fc;
            pframe_nxt = pfc;
          end
        end
        CMD_SELECT: begin
          if (!(selected_r && item.motion_id == active_r)) begin
            pframe_nxt   = frame_r;
            pkey_nxt     = key_r;
            prior_nxt    = selected_r ? active_r : item.motion_id;
            active_nxt   = item.motion_id;
            frame_nxt    = '0;
            key_nxt      = '0;
            blend_nxt    = 1'b1;
            done_nxt     = 1'b0;
            selected_nxt = 1'b1;
          end
        end
        CMD_LOAD_DUR: begin
          tbl_wr.dur_we   = 1'b1;
          tbl_wr.dur_addr = {item.motion_id, item.key_index};
          tbl_wr.dur_data = item.load_value;
        end
        default: begin
          tbl_wr.info_we    = 1'b1;
          tbl_wr.info_addr  = item.motion_id;
          tbl_wr.info_count = load_cnt;
          tbl_wr.info_loop  = item.loop_enable;
        end
      endcase
    end
  end

  // The tables are read ahead at the position the next word will start from.
  assign tbl_rd = '{cur_motion: active_nxt, cur_key: key_nxt,
                    old_motion: prior_nxt, old_key: pkey_nxt};

  assign status_nxt = '{current_motion: active_nxt, current_key: key_nxt,
                        current_frame: frame_nxt, previous_motion: prior_nxt,
                        previous_key: pkey_nxt, previous_frame: pframe_nxt,
                        blending: blend_nxt, finished: done_nxt,
                        playing: selected_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= '0;
      prior_r    <= '0;
      key_r      <= '0;
      pkey_r     <= '0;
      frame_r    <= '0;
      pframe_r   <= '0;
      selected_r <= 1'b0;
      blend_r    <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      active_r   <= active_nxt;
      prior_r    <= prior_nxt;
      key_r      <= key_nxt;
      pkey_r     <= pkey_nxt;
      frame_r    <= frame_nxt;
      pframe_r   <= pframe_nxt;
      selected_r <= selected_nxt;
      blend_r    <= blend_nxt;
      done_r     <= done_nxt;
    end
  end

endmodule

/* rtl/keyframe_motion_sequencer.sv */
// Top level of the keyframe motion sequencer: input stage, core, tables, result register.
//
//   Channel   Direction  Word                                  Handshake
//   in_ch     sink       command, motion, key, value, loop     valid/ready
//   out_ch    source     current/previous position, flags      valid/ready
//   cfg_ch    sink       blend_frames (8 bits)                 valid/ready
//
// One word is accepted per cycle unless stalled; each passes input and result registers.
// The table read for the next word is launched from the state update of the
// current one, so words follow each other at full rate.
// Reset clears the sequencer state and sets the blend length to five frames.
// A held result stalls the core; one further word waits in the input stage.
module keyframe_motion_sequencer (
  input  logic      clk,
  input  logic      rst_n,
  kms_in_if.sink    in_ch,
  kms_out_if.source out_ch,
  kms_cfg_if.sink   cfg_ch
);
  import kms_pkg::*;

  in_word_t           item_r;
  logic               item_valid_r;
  out_word_t          result_r;
  logic               result_valid_r;
  logic [BLEND_W-1:0] blend_frames_r;
  logic               adv;
  tbl_wr_t            tbl_wr;
  tbl_rd_t            tbl_rd;
  tbl_data_t          tbl_data;
  out_word_t          status_nxt;

  assign adv          = item_valid_r && (!result_valid_r || out_ch.ready);
  assign in_ch.ready  = !item_valid_r || adv;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = result_valid_r;
  assign out_ch.data  = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r   <= 1'b0;
      result_valid_r <= 1'b0;
      blend_frames_r <= BLEND_RESET;
    end else begin
      if (in_ch.ready) begin
        item_valid_r <= in_ch.valid;
      end
      if (adv) begin
        result_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        result_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        blend_frames_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r <= in_ch.data;
    end
    if (adv) begin
      result_r <= status_nxt;
    end
  end

  kms_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .item         (item_r),
    .blend_frames (blend_frames_r),
    .tbl          (tbl_data),
    .tbl_wr       (tbl_wr),
    .tbl_rd       (tbl_rd),
    .status_nxt   (status_nxt)
  );

  kms_tables u_tables (
    .clk   (clk),
    .wr    (tbl_wr),
    .rd    (tbl_rd),
    .rdata (tbl_data)
  );

endmodule

/* tb/sv/keyframe_motion_sequencer_tb.sv */
// Self-checking testbench for the keyframe motion sequencer with its own predictor.
module keyframe_motion_sequencer_tb;
  import kms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RX_OPEN = 0;
  localparam int RX_COIN = 1;
  localparam int RX_SLOW = 2;

  logic clk = 1'b0;
  logic rst_n;

  kms_in_if  in_ch ();
  kms_out_if out_ch ();
  kms_cfg_if cfg_ch ();

  keyframe_motion_sequencer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  logic [DUR_W-1:0]    key_len_tbl [DUR_DEPTH];
  logic [CNT_W-1:0]    key_cnt_tbl [MOTION_COUNT];
  logic                loops_tbl   [MOTION_COUNT];
  logic [MOTION_W-1:0] seq_motion   = '0;
  logic [KEY_W:0]      seq_key      = '0;
  logic [FRAME_BITS-1:0] seq_frame  = '0;
  logic [MOTION_W-1:0] hold_motion  = '0;
  logic [KEY_W:0]      hold_key     = '0;
  logic [FRAME_BITS-1:0] hold_frame = '0;
  logic                seq_blending = 1'b0;
  logic                seq_finished = 1'b0;
  logic                seq_playing  = 1'b0;
  logic [BLEND_W-1:0]  blend_len    = BLEND_RESET;

  out_word_t expected_status [$];
  int mismatches    = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int blend_results = 0;
  int ended_results = 0;
  int burst_left    = 0;

  function automatic out_word_t advance_sequencer(in_word_t w);
    logic [KEY_W:0] cnt;
    out_word_t r;
    case (w.command)
      CMD_TICK: begin
        if (seq_playing && !seq_finished) begin
          if (seq_frame != FRAME_MAX) seq_frame++;
          if (seq_blending && loops_tbl[hold_motion] && hold_frame != FRAME_MAX) hold_frame++;
          if (seq_blending && blend_len < seq_frame) begin
            seq_blending = 1'b0;
          end else if (!seq_blending) begin
            if (key_len_tbl[{seq_motion, seq_key[KEY_W-1:0]}] <= seq_frame) begin
              seq_key++;
              seq_frame = '0;
            end
          end else begin
            if (key_len_tbl[{seq_motion, seq_key[KEY_W-1:0]}] < seq_frame) begin
              seq_key++;
              seq_frame = '0;
            end
            if (key_len_tbl[{hold_motion, hold_key[KEY_W-1:0]}] < hold_frame) begin
              hold_key++;
              hold_frame = '0;
            end
          end
          cnt = key_cnt_tbl[seq_motion];
          if (seq_key >= cnt) begin
            seq_key = cnt - 1'b1;
            if (!loops_tbl[seq_motion]) begin
              seq_finished = 1'b1;
            end else begin
              seq_key   = '0;
              seq_frame = '0;
            end
          end
          cnt = key_cnt_tbl[hold_motion];
          if (hold_key >= cnt) hold_key = cnt - 1'b1;
        end
      end
      CMD_SELECT: begin
        if (!(seq_playing && w.motion_id == seq_motion)) begin
          hold_frame   = seq_frame;
          hold_key     = seq_key;
          hold_motion  = seq_playing ? seq_motion : w.motion_id;
          seq_motion   = w.motion_id;
          seq_frame    = '0;
          seq_key      = '0;
          seq_blending = 1'b1;
          seq_finished = 1'b0;
          seq_playing  = 1'b1;
        end
      end
      CMD_LOAD_DUR: begin
        key_len_tbl[{w.motion_id, w.key_index}] = w.load_value;
      end
      default: begin
        if (w.load_value == '0) begin
          key_cnt_tbl[w.motion_id] = CNT_W'(1);
        end else if (w.load_value > KEYS_PER_MOTION) begin
          key_cnt_tbl[w.motion_id] = KEYS_MAX;
        end else begin
          key_cnt_tbl[w.motion_id] = w.load_value[CNT_W-1:0];
        end
        loops_tbl[w.motion_id] = w.loop_enable;
      end
    endcase
    r.current_motion  = seq_motion;
    r.current_key     = seq_key[KEY_W-1:0];
    r.current_frame   = seq_frame;
    r.previous_motion = hold_motion;
    r.previous_key    = hold_key[KEY_W-1:0];
    r.previous_frame  = hold_frame;
    r.blending        = seq_blending;
    r.finished        = seq_finished;
    r.playing         = seq_playing;
    return r;
  endfunction

  function automatic string field_diffs(out_word_t e, out_word_t g);
    string s = "";
    if (g.current_motion !== e.current_motion)
      s = {s, $sformatf(" current_motion %0d/%0d", e.current_motion, g.current_motion)};
    if (g.current_key !== e.current_key)
      s = {s, $sformatf(" current_key %0d/%0d", e.current_key, g.current_key)};
    if (g.current_frame !== e.current_frame)
      s = {s, $sformatf(" current_frame %0d/%0d", e.current_frame, g.current_frame)};
    if (g.previous_motion !== e.previous_motion)
      s = {s, $sformatf(" previous_motion %0d/%0d", e.previous_motion, g.previous_motion)};
    if (g.previous_key !== e.previous_key)
      s = {s, $sformatf(" previous_key %0d/%0d", e.previous_key, g.previous_key)};
    if (g.previous_frame !== e.previous_frame)
      s = {s, $sformatf(" previous_frame %0d/%0d", e.previous_frame, g.previous_frame)};
    if (g.blending !== e.blending)
      s = {s, $sformatf(" blending %0b/%0b", e.blending, g.blending)};
    if (g.finished !== e.finished)
      s = {s, $sformatf(" finished %0b/%0b", e.finished, g.finished)};
    if (g.playing !== e.playing)
      s = {s, $sformatf(" playing %0b/%0b", e.playing, g.playing)};
    return s;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) blend_len = cfg_ch.data;
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        expected_status.push_back(advance_sequencer(in_ch.data));
        words_sent++;
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_word_t want;
    string diff;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (expected_status.size() == 0) begin
        note_mismatch($sformatf("result word %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_status.pop_front();
        diff = field_diffs(want, out_ch.data);
        if (diff != "")
          note_mismatch($sformatf("result word %0d, expected/actual:%s", results_seen, diff));
        if (want.blending) blend_results++;
        if (want.finished) ended_results++;
      end
    end
  end

  initial begin : receiver_stalls
    int seg_left;
    int mode;
    int phase;
    seg_left = 0;
    mode = RX_OPEN;
    phase = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        seg_left = $urandom_range(16, 200);
        mode = $urandom_range(RX_OPEN, RX_SLOW);
      end
      seg_left--;
      phase++;
      case (mode)
        RX_OPEN: out_ch.ready <= 1'b1;
        RX_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= (phase % 4 == 0);
      endcase
    end
  end

  function automatic in_word_t make_word(cmd_t c);
    logic [31:0] noise;
    in_word_t w;
    noise = $urandom;
    w = noise[$bits(in_word_t)-1:0];
    w.command = c;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_status.size() != 0);
  endtask

  task automatic write_blend(input logic [BLEND_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic tick(input int n);
    repeat (n) send_word(make_word(CMD_TICK));
  endtask

  task automatic select_motion(input logic [MOTION_W-1:0] m);
    in_word_t w;
    w = make_word(CMD_SELECT);
    w.motion_id = m;
    send_word(w);
  endtask

  task automatic load_key(input logic [MOTION_W-1:0] m, input logic [KEY_W-1:0] k,
                          input logic [VALUE_W-1:0] d);
    in_word_t w;
    w = make_word(CMD_LOAD_DUR);
    w.motion_id  = m;
    w.key_index  = k;
    w.load_value = d;
    send_word(w);
  endtask

  task automatic load_info(input logic [MOTION_W-1:0] m, input logic [VALUE_W-1:0] cnt,
                           input logic lp);
    in_word_t w;
    w = make_word(CMD_LOAD_INFO);
    w.motion_id   = m;
    w.load_value  = cnt;
    w.loop_enable = lp;
    send_word(w);
  endtask

  task automatic fill_tables();
    for (int m = 0; m < MOTION_COUNT; m++) begin
      load_info(MOTION_W'(m), VALUE_W'($urandom_range(1, 6)), m[0]);
      for (int k = 0; k < KEYS_PER_MOTION; k++)
        load_key(MOTION_W'(m), KEY_W'(k), VALUE_W'($urandom_range(0, 6)));
    end
  endtask

  task automatic test_ticks_before_select();
    tick(3);
  endtask

  task automatic test_first_select();
    load_info(1, 3, 1'b1);
    load_key(1, 0, 0);
    load_key(1, 1, 1);
    load_key(1, 2, 2);
    select_motion(1);
    tick(8);
    select_motion(1);
    tick(2);
  endtask

  task automatic test_count_clamp_and_end();
    load_info(2, 0, 1'b0);
    load_info(3, 17, 1'b1);
    load_info(4, 16'hFFFF, 1'b0);
    load_key(2, 0, 0);
    select_motion(2);
    tick(3);
    select_motion(2);
    select_motion(3);
    tick(2);
  endtask

  task automatic test_stale_previous_key();
    load_info(5, 4, 1'b1);
    for (int k = 0; k < 4; k++) load_key(5, KEY_W'(k), 0);
    select_motion(5);
    tick(3);
    select_motion(6);
    load_info(5, 1, 1'b1);
    tick(2);
  endtask

  task automatic test_long_key();
    drain();
    write_blend(8'hFF);
    load_info(7, 1, 1'b1);
    load_key(7, 0, 16'hFFFF);
    select_motion(7);
    tick(260);
    select_motion(6);
    tick(4);
    drain();
  endtask

  task automatic test_random_play(input logic [BLEND_W-1:0] blend, input int n);
    in_word_t w;
    int pick;
    drain();
    write_blend(blend);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        w = make_word(CMD_TICK);
      end else if (pick < 77) begin
        w = make_word(CMD_SELECT);
      end else if (pick < 89) begin
        w = make_word(CMD_LOAD_DUR);
        if ($urandom_range(0, 19) != 0) w.load_value = VALUE_W'($urandom_range(0, 8));
      end else begin
        w = make_word(CMD_LOAD_INFO);
        if ($urandom_range(0, 9) != 0) w.load_value = VALUE_W'($urandom_range(0, 18));
      end
      send_word(w);
    end
    drain();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fill_tables();
    test_ticks_before_select();
    test_first_select();
    test_count_clamp_and_end();
    test_stale_previous_key();
    test_long_key();
    test_random_play(8'd0, 280);
    test_random_play(BLEND_W'($urandom_range(1, 254)), 280);
    test_random_play(8'hFF, 280);
    test_random_play(BLEND_RESET, 280);

    repeat (20) @(posedge clk);
    if (expected_status.size() != 0)
      note_mismatch($sformatf("%0d expected result words never arrived", expected_status.size()));
    $display("Sent %0d command words and checked %0d result words over blend lengths 0 to 255;",
             words_sent, results_seen);
    $display("%0d results fell in a blend window and %0d after a motion had ended.",
             blend_results, ended_results);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d result words still expected.", expected_status.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/kms_pkg.sv
rtl/kms_in_if.sv
rtl/kms_out_if.sv
rtl/kms_cfg_if.sv
rtl/kms_tables.sv
rtl/kms_core.sv
rtl/keyframe_motion_sequencer.sv
tb/sv/keyframe_motion_sequencer_tb.sv
